// ===== src/dert_pkg.sv =====
`default_nettype none

package dert_pkg;

    // input item kinds
    localparam logic [1:0] ACT_START = 2'd0;
    localparam logic [1:0] ACT_TICK  = 2'd1;
    localparam logic [1:0] ACT_EDGE  = 2'd2;

    // configuration register indexes
    localparam logic [1:0] CFG_PING_TIMEOUT = 2'd0;
    localparam logic [1:0] CFG_ECHO_TIMEOUT = 2'd1;
    localparam logic [1:0] CFG_SPEED_SCALE  = 2'd2;

    localparam int TMR_W     = 16;
    localparam int SCALE_W   = 16;
    localparam int DIST_W    = 14;
    localparam int DUR_LOW_W = 30;
    localparam int PROD_W    = DUR_LOW_W + SCALE_W;

    localparam logic [DIST_W-1:0] DIST_MAX = 14'd16383;

    // reset values of the configuration registers
    localparam logic [TMR_W-1:0]   PING_TIMEOUT_RST = 16'd50012;
    localparam logic [TMR_W-1:0]   ECHO_TIMEOUT_RST = 16'd23324;
    localparam logic [SCALE_W-1:0] SPEED_SCALE_RST  = 16'd11239;

    typedef enum logic [1:0] {
        ST_DONE      = 2'd0,
        ST_PING_TO   = 2'd1,
        ST_ECHO_TO   = 2'd2,
        ST_ECHO_ERR  = 2'd3
    } t_status;

    // pulse duration: saturation flag (duration >= 2^30) and low bits
    typedef struct packed {
        logic                 sat;
        logic [DUR_LOW_W-1:0] low;
    } t_dur;

endpackage

`default_nettype wire

// ===== src/dert_mm_scale.sv =====
`default_nettype none

module dert_mm_scale (
    input  wire dert_pkg::t_dur                    i_dur,
    input  wire logic [dert_pkg::SCALE_W-1:0]      i_scale,
    output logic      [dert_pkg::DIST_W-1:0]       o_mm
);
    import dert_pkg::*;

    logic [PROD_W-1:0] prod;

    // duration times Q16 scale, then drop the fraction
    assign prod = PROD_W'(i_dur.low) * PROD_W'(i_scale);

    // zero scale gives zero distance; otherwise saturate at the largest distance
    always_comb begin
        if (i_scale == '0) begin
            o_mm = '0;
        end else if (i_dur.sat || (|prod[PROD_W-1:SCALE_W+DIST_W])) begin
            o_mm = DIST_MAX;
        end else begin
            o_mm = prod[SCALE_W+DIST_W-1:SCALE_W];
        end
    end

endmodule

`default_nettype wire

// ===== src/dual_echo_range_timer.sv =====
`default_nettype none
// A result item shows on the master side once the item that causes it is accepted, through
// stage 1 (status and durations), then the scale multiply into the output register.
// Throughput: one input item per cycle unless a held result stalls; accepted items update timers.
// Reset (synchronous, active low) clears the measurement state, the tick counter and the
// pipeline, and loads the configuration registers with their default values.

module dual_echo_range_timer #(
    parameter int TIME_WIDTH = 32
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,

    input  wire logic                         i_cfg_we,
    input  wire logic [1:0]                   i_cfg_index,
    input  wire logic [dert_pkg::TMR_W-1:0]   i_cfg_data,

    input  wire logic                         s_axis_tvalid,
    output logic                              s_axis_tready,
    input  wire logic [7:0]                   s_axis_tdata,   // [0] side, [1] level
    input  wire logic [1:0]                   s_axis_tuser,   // [1:0] action

    output logic                              m_axis_tvalid,
    input  wire logic                         m_axis_tready,
    output logic [31:0]                       m_axis_tdata,   // [13:0] left mm, [27:14] right mm
    output logic [1:0]                        m_axis_tuser    // [1:0] status
);
    import dert_pkg::*;

    localparam int DUR_EXT_W = (TIME_WIDTH > DUR_LOW_W) ? TIME_WIDTH : DUR_LOW_W + 1;

    // configuration
    logic [TMR_W-1:0]   r_ping_to;
    logic [TMR_W-1:0]   r_echo_to;
    logic [SCALE_W-1:0] r_scale;

    // measurement state
    logic                  r_busy,      n_busy;
    logic [TIME_WIDTH-1:0] r_now,       n_now;
    logic [TMR_W-1:0]      r_ping_rem,  n_ping_rem;
    logic [TMR_W-1:0]      r_echo_rem [2];
    logic [TMR_W-1:0]      n_echo_rem [2];
    logic [1:0]            r_armed,     n_armed;
    logic [TIME_WIDTH-1:0] r_start [2];
    logic [TIME_WIDTH-1:0] n_start [2];
    logic [TIME_WIDTH-1:0] r_end [2];
    logic [TIME_WIDTH-1:0] n_end [2];
    logic [1:0]            r_end_seen,  n_end_seen;

    // result of the current item
    logic    res_valid;
    t_status res_status;
    t_dur    res_dur [2];

    // pipeline
    logic    r_s1_valid;
    t_status r_s1_status;
    t_dur    r_s1_dur [2];
    logic    r_m_valid;
    t_status r_m_status;
    logic [DIST_W-1:0] r_m_left;
    logic [DIST_W-1:0] r_m_right;

    logic [DIST_W-1:0] mm_left;
    logic [DIST_W-1:0] mm_right;

    logic       acc;
    logic       s1_adv;
    logic [1:0] in_action;
    logic       in_side;
    logic       in_level;
    logic       expired;
    logic [TIME_WIDTH-1:0] dur_raw [2];
    logic [DUR_EXT_W-1:0]  dur_ext [2];

    assign in_action = s_axis_tuser;
    assign in_side   = s_axis_tdata[0];
    assign in_level  = s_axis_tdata[1];

    // handshake: output register frees stage 1, stage 1 frees the input
    assign s1_adv        = !r_m_valid || m_axis_tready;
    assign s_axis_tready = !r_s1_valid || s1_adv;
    assign acc           = s_axis_tvalid && s_axis_tready;

    // next state and result for one item
    always_comb begin
        n_busy     = r_busy;
        n_now      = r_now;
        n_ping_rem = r_ping_rem;
        n_echo_rem = r_echo_rem;
        n_armed    = r_armed;
        n_start    = r_start;
        n_end      = r_end;
        n_end_seen = r_end_seen;
        res_valid  = 1'b0;
        res_status = ST_DONE;
        expired    = 1'b0;

        case (in_action)
            ACT_START: begin
                n_busy     = 1'b1;
                n_ping_rem = r_ping_to;
                n_echo_rem = '{default: '0};
                n_armed    = '0;
                n_start    = '{default: '0};
                n_end      = '{default: '0};
                n_end_seen = '0;
            end
            ACT_TICK: begin
                n_now = r_now + 1'b1;
                if (r_busy) begin
                    if (r_ping_rem <= TMR_W'(1)) begin
                        res_valid  = 1'b1;
                        res_status = ST_PING_TO;
                    end else begin
                        n_ping_rem = r_ping_rem - 1'b1;
                        for (int s = 0; s < 2; s++) begin
                            if (r_armed[s]) begin
                                if (r_echo_rem[s] <= TMR_W'(1)) begin
                                    expired = 1'b1;
                                end else begin
                                    n_echo_rem[s] = r_echo_rem[s] - 1'b1;
                                end
                            end
                        end
                        if (expired) begin
                            res_valid  = 1'b1;
                            res_status = ST_ECHO_TO;
                        end
                    end
                end
            end
            ACT_EDGE: begin
                if (r_busy) begin
                    if (in_level) begin
                        n_start[in_side] = r_now;
                        if (r_armed[in_side]) begin
                            res_valid  = 1'b1;
                            res_status = ST_ECHO_ERR;
                        end else begin
                            n_armed[in_side]    = 1'b1;
                            n_echo_rem[in_side] = r_echo_to;
                        end
                    end else begin
                        n_end[in_side]      = r_now;
                        n_armed[in_side]    = 1'b0;
                        n_echo_rem[in_side] = '0;
                        n_end_seen[in_side] = 1'b1;
                        if (r_end_seen[!in_side]) begin
                            res_valid  = 1'b1;
                            res_status = ST_DONE;
                        end
                    end
                end
            end
            default: begin
            end
        endcase

        // any result ends the measurement
        if (res_valid) begin
            n_busy     = 1'b0;
            n_ping_rem = '0;
            n_echo_rem = '{default: '0};
            n_armed    = '0;
        end
    end

    // pulse durations, modulo the time width; zero unless done
    always_comb begin
        for (int s = 0; s < 2; s++) begin
            dur_raw[s] = n_end[s] - n_start[s];
            dur_ext[s] = DUR_EXT_W'(dur_raw[s]);
            if (res_status == ST_DONE) begin
                res_dur[s].sat = |dur_ext[s][DUR_EXT_W-1:DUR_LOW_W];
                res_dur[s].low = dur_ext[s][DUR_LOW_W-1:0];
            end else begin
                res_dur[s] = '0;
            end
        end
    end

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ping_to <= PING_TIMEOUT_RST;
            r_echo_to <= ECHO_TIMEOUT_RST;
            r_scale   <= SPEED_SCALE_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_PING_TIMEOUT: r_ping_to <= i_cfg_data;
                CFG_ECHO_TIMEOUT: r_echo_to <= i_cfg_data;
                CFG_SPEED_SCALE:  r_scale   <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // measurement state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy     <= 1'b0;
            r_now      <= '0;
            r_ping_rem <= '0;
            r_echo_rem <= '{default: '0};
            r_armed    <= '0;
            r_start    <= '{default: '0};
            r_end      <= '{default: '0};
            r_end_seen <= '0;
        end else if (acc) begin
            r_busy     <= n_busy;
            r_now      <= n_now;
            r_ping_rem <= n_ping_rem;
            r_echo_rem <= n_echo_rem;
            r_armed    <= n_armed;
            r_start    <= n_start;
            r_end      <= n_end;
            r_end_seen <= n_end_seen;
        end
    end

    // stage 1: status and durations
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_s1_valid <= acc && res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_s1_status <= res_status;
            r_s1_dur    <= res_dur;
        end
    end

    dert_mm_scale u_scale_left (
        .i_dur   (r_s1_dur[0]),
        .i_scale (r_scale),
        .o_mm    (mm_left)
    );

    dert_mm_scale u_scale_right (
        .i_dur   (r_s1_dur[1]),
        .i_scale (r_scale),
        .o_mm    (mm_right)
    );

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (s1_adv) begin
            r_m_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv && r_s1_valid) begin
            r_m_status <= r_s1_status;
            r_m_left   <= mm_left;
            r_m_right  <= mm_right;
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tuser  = r_m_status;
    assign m_axis_tdata  = {4'd0, r_m_right, r_m_left};

    // any result leaves the block idle
    a_result_idles: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && res_valid) |=> !r_busy)
        else $error("block still busy after a result");

    // idle means no timer is running
    a_idle_disarmed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_busy |-> (r_armed == 2'b00) && (r_ping_rem == '0))
        else $error("timer armed while idle");

    // error results carry zero distances
    a_error_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_m_valid && (r_m_status != ST_DONE)) |-> (r_m_left == '0) && (r_m_right == '0))
        else $error("nonzero distance on an error result");

    // a stalled stage 1 item holds
    a_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !s1_adv) |=> r_s1_valid && $stable(r_s1_status)
            && $stable(r_s1_dur[0]) && $stable(r_s1_dur[1]))
        else $error("stage 1 item lost under stall");

endmodule

`default_nettype wire

// ===== verif/dert_range_checker.sv =====
`timescale 1ns / 100ps

// Watches the configuration port and both stream channels of the echo range timer.
// Keeps its own copy of the measurement state, predicts the report, if any, of each accepted
// input item and compares every accepted report against the oldest prediction.
module dert_range_checker (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,

    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [15:0] i_cfg_data,

    input  wire logic        i_s_tvalid,
    input  wire logic        i_s_tready,
    input  wire logic [7:0]  i_s_tdata,    // [0] side, [1] level
    input  wire logic [1:0]  i_s_tuser,    // [1:0] action

    input  wire logic        i_m_tvalid,
    input  wire logic        i_m_tready,
    input  wire logic [31:0] i_m_tdata,    // [13:0] left mm, [27:14] right mm
    input  wire logic [1:0]  i_m_tuser,    // [1:0] status

    output int               o_fail_count,
    output int               o_pending,
    output int               o_checked,
    output int               o_done_count
);

    import dert_pkg::*;

    localparam int TIME_W = 32;

    typedef struct packed {
        t_status           status;
        logic [DIST_W-1:0] left_mm;
        logic [DIST_W-1:0] right_mm;
    } t_range_report;

    // register copies
    logic [TMR_W-1:0]   ping_limit;
    logic [TMR_W-1:0]   echo_limit;
    logic [SCALE_W-1:0] half_speed_q16;

    // measurement state
    logic              busy;
    logic [TIME_W-1:0] now_us;
    logic [TMR_W-1:0]  ping_left;
    logic [TMR_W-1:0]  echo_rem_ticks [2];
    logic              echo_armed [2];
    logic [TIME_W-1:0] pulse_start[2];
    logic [TIME_W-1:0] pulse_end  [2];
    logic              end_seen   [2];

    t_range_report expected_reports[$];
    t_range_report want;

    function automatic logic [DIST_W-1:0] pulse_to_mm(logic [TIME_W-1:0] dur);
        logic [47:0] prod;
        if (half_speed_q16 == '0)
            return '0;
        if (dur >= 32'h4000_0000)
            return DIST_MAX;
        prod = {16'd0, dur} * {32'd0, half_speed_q16};
        prod = prod >> 16;
        if (prod > DIST_MAX)
            return DIST_MAX;
        return prod[DIST_W-1:0];
    endfunction

    task automatic stop_timers();
        busy              = 1'b0;
        ping_left         = '0;
        echo_rem_ticks[0] = '0;
        echo_rem_ticks[1] = '0;
        echo_armed[0]     = 1'b0;
        echo_armed[1]     = 1'b0;
    endtask

    task automatic add_report(t_status st, logic [DIST_W-1:0] l_mm, logic [DIST_W-1:0] r_mm);
        t_range_report rep;
        rep.status   = st;
        rep.left_mm  = l_mm;
        rep.right_mm = r_mm;
        expected_reports.push_back(rep);
    endtask

    // one input item through the measurement state
    task automatic predict_ranging(logic [1:0] act, logic side, logic level);
        logic              expired;
        logic [TIME_W-1:0] dur_l;
        logic [TIME_W-1:0] dur_r;
        case (act)
            ACT_START: begin
                stop_timers();
                busy      = 1'b1;
                ping_left = ping_limit;
                for (int s = 0; s < 2; s++) begin
                    pulse_start[s] = '0;
                    pulse_end[s]   = '0;
                    end_seen[s]    = 1'b0;
                end
            end
            ACT_TICK: begin
                now_us = now_us + 1'b1;
                if (busy) begin
                    // ping timer wins over the echo timers
                    if (ping_left <= 1) begin
                        stop_timers();
                        add_report(ST_PING_TO, '0, '0);
                    end else begin
                        ping_left = ping_left - 1'b1;
                        expired   = 1'b0;
                        for (int s = 0; s < 2; s++) begin
                            if (echo_armed[s]) begin
                                if (echo_rem_ticks[s] <= 1)
                                    expired = 1'b1;
                                else
                                    echo_rem_ticks[s] = echo_rem_ticks[s] - 1'b1;
                            end
                        end
                        if (expired) begin
                            stop_timers();
                            add_report(ST_ECHO_TO, '0, '0);
                        end
                    end
                end
            end
            ACT_EDGE: begin
                if (busy && level) begin
                    pulse_start[side] = now_us;
                    if (echo_armed[side]) begin
                        stop_timers();
                        add_report(ST_ECHO_ERR, '0, '0);
                    end else begin
                        echo_armed[side]     = 1'b1;
                        echo_rem_ticks[side] = echo_limit;
                    end
                end else if (busy) begin
                    pulse_end[side]      = now_us;
                    echo_armed[side]     = 1'b0;
                    echo_rem_ticks[side] = '0;
                    end_seen[side]       = 1'b1;
                    if (end_seen[side ^ 1'b1]) begin
                        dur_l = pulse_end[0] - pulse_start[0];
                        dur_r = pulse_end[1] - pulse_start[1];
                        stop_timers();
                        add_report(ST_DONE, pulse_to_mm(dur_l), pulse_to_mm(dur_r));
                    end
                end
            end
            default: ;
        endcase
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            ping_limit     = PING_TIMEOUT_RST;
            echo_limit     = ECHO_TIMEOUT_RST;
            half_speed_q16 = SPEED_SCALE_RST;
            stop_timers();
            now_us = '0;
            for (int s = 0; s < 2; s++) begin
                pulse_start[s] = '0;
                pulse_end[s]   = '0;
                end_seen[s]    = 1'b0;
            end
            expected_reports.delete();
        end else begin
            // register writes
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_PING_TIMEOUT: ping_limit     = i_cfg_data;
                    CFG_ECHO_TIMEOUT: echo_limit     = i_cfg_data;
                    CFG_SPEED_SCALE:  half_speed_q16 = i_cfg_data;
                    default: ;
                endcase
            end

            if (i_s_tvalid && i_s_tready)
                predict_ranging(i_s_tuser, i_s_tdata[0], i_s_tdata[1]);

            // report compare
            if (i_m_tvalid && i_m_tready) begin
                if (expected_reports.size() == 0) begin
                    $error("unexpected report: status %0d, left %0d, right %0d",
                           i_m_tuser, i_m_tdata[13:0], i_m_tdata[27:14]);
                    o_fail_count++;
                end else begin
                    want = expected_reports.pop_front();
                    o_checked++;
                    if (want.status == ST_DONE)
                        o_done_count++;
                    if (i_m_tuser !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, i_m_tuser);
                        o_fail_count++;
                    end
                    if (i_m_tdata[13:0] !== want.left_mm) begin
                        $error("distance_left_mm: expected %0d, got %0d",
                               want.left_mm, i_m_tdata[13:0]);
                        o_fail_count++;
                    end
                    if (i_m_tdata[27:14] !== want.right_mm) begin
                        $error("distance_right_mm: expected %0d, got %0d",
                               want.right_mm, i_m_tdata[27:14]);
                        o_fail_count++;
                    end
                end
            end
        end
        o_pending = expected_reports.size();
    end

endmodule

// ===== verif/dual_echo_range_timer_tb.sv =====
`timescale 1ns / 100ps

module dual_echo_range_timer_tb;

    import dert_pkg::*;

    localparam logic [1:0] ACT_UNUSED = 2'd3;
    localparam int         NUM_PHASES = 8;
    localparam int         SEQS_PER_PHASE = 4;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [1:0]  i_cfg_index;
    logic [15:0] i_cfg_data;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;    // [0] side, [1] level
    logic [1:0]  s_axis_tuser;    // [1:0] action
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;    // [13:0] left mm, [27:14] right mm
    logic [1:0]  m_axis_tuser;    // [1:0] status

    int fail_count;
    int pending;
    int checked;
    int done_count;
    int items_sent;
    int settings_count;
    int src_idle_pct;
    int snk_idle_pct;

    // per phase: ping ticks, echo ticks, speed scale (-1 random), largest tick gap
    int plan_ping [NUM_PHASES] = '{65535, 1, 300, 60, 200, 120, 0, 500};
    int plan_echo [NUM_PHASES] = '{65535, 1, 40, 0, 25, 65535, 8, 100};
    int plan_scale[NUM_PHASES] = '{65535, 0, -1, -1, -1, -1, 1, -1};
    int plan_gap  [NUM_PHASES] = '{12, 1, 30, 3, 20, 25, 2, 40};

    dual_echo_range_timer u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    dert_range_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_s_tvalid   (s_axis_tvalid),
        .i_s_tready   (s_axis_tready),
        .i_s_tdata    (s_axis_tdata),
        .i_s_tuser    (s_axis_tuser),
        .i_m_tvalid   (m_axis_tvalid),
        .i_m_tready   (m_axis_tready),
        .i_m_tdata    (m_axis_tdata),
        .i_m_tuser    (m_axis_tuser),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked),
        .o_done_count (done_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // hard stop
    initial begin
        #50_000_000;
        $display("Timeout: run did not finish in time");
        $display("FAILED: results differ");
        $finish;
    end

    // report sink with random stall bursts
    initial begin
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (snk_idle_pct != 0 && $urandom_range(0, 99) < snk_idle_pct) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 11)) @(negedge i_clk);
            end
            m_axis_tready <= 1'b1;
        end
    end

    // Present one item at a falling edge and hold it until accepted.
    // Leaves tvalid high; the next call or a drain decides what follows.
    task automatic push_item(logic [1:0] act, logic side, logic level);
        if (src_idle_pct != 0 && $urandom_range(0, 99) < src_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= act;
        s_axis_tdata  <= {6'd0, level, side};
        do
            @(posedge i_clk);
        while (!s_axis_tready);
        items_sent++;
        @(negedge i_clk);
    endtask

    task automatic ticks(int n);
        repeat (n) push_item(ACT_TICK, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    endtask

    // random tick gap inside a measurement
    task automatic tick_gap(int max_gap);
        int n;
        n = $urandom_range(0, max_gap);
        ticks(n);
    endtask

    // stop sending and wait for every predicted report, then for the pipeline
    task automatic drain_reports(int max_cycles);
        int n;
        n = 0;
        s_axis_tvalid <= 1'b0;
        while (pending != 0 && n < max_cycles) begin
            @(negedge i_clk);
            n++;
        end
        repeat (8) @(negedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [15:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        @(negedge i_clk);
    endtask

    task automatic load_settings(logic [15:0] ping, logic [15:0] echo, logic [15:0] scale);
        write_reg(CFG_PING_TIMEOUT, ping);
        write_reg(CFG_ECHO_TIMEOUT, echo);
        write_reg(CFG_SPEED_SCALE, scale);
        i_cfg_we <= 1'b0;
        settings_count++;
    endtask

    task automatic noise_item();
        push_item(2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    endtask

    // start, then a falling edge per side, mostly after a rising edge, in random order with random gaps and some noise
    task automatic run_measurement(int max_gap);
        bit rose[2];
        bit fell[2];
        int s;
        rose = '{0, 0};
        fell = '{0, 0};
        push_item(ACT_START, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        while (!(fell[0] && fell[1])) begin
            s = $urandom_range(0, 1);
            if (fell[s])
                s = 1 - s;
            tick_gap(max_gap);
            if (!rose[s] && $urandom_range(0, 7) != 0) begin
                push_item(ACT_EDGE, 1'(s), 1'b1);
                rose[s] = 1'b1;
            end else begin
                push_item(ACT_EDGE, 1'(s), 1'b0);
                fell[s] = 1'b1;
            end
            if ($urandom_range(0, 15) == 0)
                noise_item();
        end
    endtask

    initial begin
        int scale;
        i_rst_n        = 1'b0;
        i_cfg_we       = 1'b0;
        i_cfg_index    = '0;
        i_cfg_data     = '0;
        s_axis_tvalid  = 1'b0;
        s_axis_tdata   = '0;
        s_axis_tuser   = '0;
        items_sent     = 0;
        settings_count = 1;
        src_idle_pct   = 0;
        snk_idle_pct   = 0;

        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed, register values from reset
        push_item(ACT_EDGE, 1'b0, 1'b1);     // edges while idle are dropped
        push_item(ACT_EDGE, 1'b1, 1'b0);
        push_item(ACT_UNUSED, 1'b1, 1'b1);   // unknown action
        push_item(ACT_START, 1'b0, 1'b0);
        push_item(ACT_EDGE, 1'b0, 1'b1);
        ticks(3);
        push_item(ACT_EDGE, 1'b1, 1'b1);
        ticks(2);
        push_item(ACT_EDGE, 1'b0, 1'b0);
        ticks(1);
        push_item(ACT_EDGE, 1'b0, 1'b0);     // second falling edge overwrites the end
        ticks(2);
        push_item(ACT_EDGE, 1'b1, 1'b0);
        // falling edges with no rising edge measure from zero
        push_item(ACT_START, 1'b1, 1'b1);
        push_item(ACT_EDGE, 1'b1, 1'b0);
        push_item(ACT_EDGE, 1'b0, 1'b0);
        // end before start on the left: duration wraps and saturates
        push_item(ACT_START, 1'b0, 1'b0);
        push_item(ACT_EDGE, 1'b0, 1'b0);
        ticks(1);
        push_item(ACT_EDGE, 1'b0, 1'b1);
        push_item(ACT_EDGE, 1'b1, 1'b0);
        // restart while busy, then a repeated rising edge
        push_item(ACT_START, 1'b0, 1'b0);
        push_item(ACT_EDGE, 1'b1, 1'b1);
        push_item(ACT_START, 1'b0, 1'b0);
        push_item(ACT_EDGE, 1'b1, 1'b1);
        push_item(ACT_EDGE, 1'b1, 1'b1);
        drain_reports(2000);

        // short timers: both echo timers expire on one tick, then a ping timeout
        load_settings(16'd4, 16'd2, 16'd65535);
        push_item(ACT_START, 1'b0, 1'b0);
        push_item(ACT_EDGE, 1'b0, 1'b1);
        push_item(ACT_EDGE, 1'b1, 1'b1);
        ticks(2);
        push_item(ACT_START, 1'b0, 1'b0);
        ticks(4);
        drain_reports(2000);

        // zero registers
        load_settings(16'd0, 16'd0, 16'd0);
        push_item(ACT_START, 1'b0, 1'b0);
        ticks(1);
        push_item(ACT_START, 1'b0, 1'b0);
        push_item(ACT_EDGE, 1'b0, 1'b1);
        push_item(ACT_EDGE, 1'b0, 1'b0);
        push_item(ACT_EDGE, 1'b1, 1'b1);
        push_item(ACT_EDGE, 1'b1, 1'b0);
        drain_reports(2000);

        // random phases, one register setting each; the last one runs without idling
        for (int p = 0; p < NUM_PHASES; p++) begin
            scale = plan_scale[p] < 0 ? $urandom_range(1, 65535) : plan_scale[p];
            load_settings(16'(plan_ping[p]), 16'(plan_echo[p]), 16'(scale));
            src_idle_pct = p == NUM_PHASES - 1 ? 0 : $urandom_range(0, 3) * 10;
            snk_idle_pct = p == NUM_PHASES - 1 ? 0 : $urandom_range(0, 3) * 10;
            for (int q = 0; q < SEQS_PER_PHASE; q++) begin
                if ($urandom_range(0, 4) == 0) begin
                    repeat ($urandom_range(1, 12)) noise_item();
                end else begin
                    run_measurement(plan_gap[p]);
                end
                if ($urandom_range(0, 19) == 0)
                    drain_reports(2000);
            end
            drain_reports(2000);
        end

        if (pending != 0)
            $error("%0d expected reports never arrived", pending);
        $display("Sent %0d input items under %0d register settings.", items_sent, settings_count);
        $display("Checked %0d reports, %0d of them with distances.", checked, done_count);
        if (fail_count == 0 && pending == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

// ===== dual_echo_range_timer.f =====
src/dert_pkg.sv
src/dert_mm_scale.sv
src/dual_echo_range_timer.sv
verif/dert_range_checker.sv
verif/dual_echo_range_timer_tb.sv
